### src/bef_pkg.sv
// Shared constants, types and tables of the band-edge frequency-locked loop.
package bef_pkg;

    localparam int TAP_COUNT   = 45;
    localparam int SAMPLE_BITS = 16;
    localparam int PHASE_BITS  = 24;
    localparam int ROM_HALF    = 22;
    localparam int CENTER_TAP  = (TAP_COUNT - 1) / 2;
    localparam int GAIN_BITS   = 20;
    localparam int FREQ_BITS   = PHASE_BITS + 2;
    localparam int PTR_W       = $clog2(TAP_COUNT);
    localparam int COEF_BITS   = 18;
    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS    = PROD_BITS + 8;
    localparam int LVL_BITS    = ACC_BITS - SAMPLE_BITS + 2;
    localparam int SQ_BITS     = 2 * LVL_BITS;
    localparam int ERR_BITS    = 25;
    localparam int INV_BITS    = 32;
    localparam int ERRT_BITS   = ERR_BITS + INV_BITS - 16;
    localparam int DF_BITS     = ERRT_BITS + GAIN_BITS + 1 - (52 - PHASE_BITS);
    localparam int CFG_INDEX_BITS = 8;

    localparam logic [INV_BITS-1:0] INV_TWO_PI_Q32 = 32'd683565276;
    localparam int ERR_LIMIT = 16777215;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PROP_GAIN  = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INTEG_GAIN = 8'd1;

    localparam logic [GAIN_BITS-1:0] PROP_GAIN_RESET  = 20'd89128;
    localparam logic [GAIN_BITS-1:0] INTEG_GAIN_RESET = 20'd3960;

    localparam int QSINE [0:64] = '{
        0, 402, 804, 1205, 1606, 2006, 2404, 2801, 3196, 3590, 3981, 4370, 4756,
        5139, 5520, 5897, 6270, 6639, 7005, 7366, 7723, 8076, 8423, 8765, 9102,
        9434, 9760, 10080, 10394, 10702, 11003, 11297, 11585, 11866, 12140, 12406,
        12665, 12916, 13160, 13395, 13623, 13842, 14053, 14256, 14449, 14635,
        14811, 14978, 15137, 15286, 15426, 15557, 15679, 15791, 15893, 15986,
        16069, 16143, 16207, 16261, 16305, 16340, 16364, 16379, 16384
    };

    localparam int EDGE_RE [0:ROM_HALF] = '{
        29206, -13584, -8118, 8433, -776, 702, -1649, 129, -241, 654, 0, 104,
        -323, -42, -46, 175, 59, 16, -97, -64, 0, 53, 65
    };
    localparam int EDGE_IM [0:ROM_HALF] = '{
        0, -22167, 15933, -664, -1067, -1696, 261, 151, 740, -157, 0, -434,
        105, -36, 289, -72, 43, -204, 49, -39, 150, -32, 33
    };

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ROT_MUL,
        S_ROT_SUM,
        S_MAC,
        S_DRAIN,
        S_SQR,
        S_ERR,
        S_ERRT,
        S_GAIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic issue;
        logic clear;
    } mac_ctl_t;

    // Sine in Q1.14 at one of 256 steps per turn.
    function automatic logic signed [15:0] sine_at(input logic [7:0] idx);
        logic [6:0] r;
        logic [6:0] rr;
        logic signed [15:0] a;
        logic signed [15:0] b;
        r  = {1'b0, idx[5:0]};
        rr = 7'd64 - r;
        a  = 16'(QSINE[r]);
        b  = 16'(QSINE[rr]);
        case (idx[7:6])
            2'd0:    sine_at = a;
            2'd1:    sine_at = b;
            2'd2:    sine_at = -a;
            default: sine_at = -b;
        endcase
    endfunction

    // Lower band-edge tap at delay position k; zero beyond the stored half.
    function automatic logic signed [COEF_BITS-1:0] tap_re(input logic [PTR_W-1:0] k);
        int n;
        int m;
        n = int'(k) - CENTER_TAP;
        m = (n < 0) ? -n : n;
        if (m > ROM_HALF)
            tap_re = '0;
        else
            tap_re = COEF_BITS'(EDGE_RE[m]);
    endfunction

    function automatic logic signed [COEF_BITS-1:0] tap_im(input logic [PTR_W-1:0] k);
        int n;
        int m;
        n = int'(k) - CENTER_TAP;
        m = (n < 0) ? -n : n;
        if (m > ROM_HALF)
            tap_im = '0;
        else if (n >= 0)
            tap_im = COEF_BITS'(EDGE_IM[m]);
        else
            tap_im = COEF_BITS'(-EDGE_IM[m]);
    endfunction

endpackage

### src/band_edge_fll_carrier_recovery_top.sv
// Top level of the band-edge frequency-locked loop carrier recovery block.
//
//  channel | signals                                   | direction | content
//  --------+-------------------------------------------+-----------+-------------------------
//  input   | s_tvalid, s_tready, s_tdata[31:0]         | in        | sample_i, sample_q
//  output  | m_tvalid, m_tready, m_tdata[63:0]         | out       | out_i, out_q, freq_word
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in        | prop_gain, integ_gain
//
// Each sample is rotated, filtered by a serial pass over the delay line, squared,
// turned into an error, scaled and weighted by the gains before it loads the output
// register; the next sample is accepted only after the block is back in idle. The
// serial pass over the delay-line RAM, one tap per cycle through its single read port,
// bounds the sample rate. After reset a clearing pass zeroes the delay line; no
// sample is taken meanwhile, configuration writes are.
// A finished result waits in the output register while the next sample is
// accepted; the block holds in its final step only while that register is full and not taken.
module band_edge_fll_carrier_recovery_top import bef_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [31:0]               s_tdata,   // sample_i[15:0], sample_q[31:16]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [63:0]               m_tdata,   // out_i[15:0], out_q[31:16], freq_word[57:32]
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [GAIN_BITS-1:0]      cfg_data
);

    localparam int ROT_BITS = SAMPLE_BITS + 16;
    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [PHASE_BITS:0] PH_HALF = (PHASE_BITS+1)'(1) << (PHASE_BITS - 9);
    localparam int DIFF_BITS = SQ_BITS + 2;
    localparam int FSUM_BITS = DF_BITS + 1;
    localparam logic [PTR_W-1:0] LAST_TAP = PTR_W'(TAP_COUNT - 1);

    state_t state_reg, state_next;

    logic [PTR_W-1:0] cnt_reg, cnt_next;
    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] raddr_reg;

    logic [GAIN_BITS-1:0] prop_gain_reg, integ_gain_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic signed [FREQ_BITS-1:0] freq_reg;

    logic m_tvalid_reg;
    logic [63:0] m_tdata_reg;

    // datapath registers
    logic signed [SAMPLE_BITS-1:0] xi_reg, xq_reg;
    logic signed [ROT_BITS-1:0]    p_xc_reg, p_ys_reg, p_xs_reg, p_yc_reg;
    logic signed [SAMPLE_BITS-1:0] yi_reg, yq_reg;
    logic signed [SQ_BITS-1:0]     sq_lr_reg, sq_li_reg, sq_ur_reg, sq_ui_reg;
    logic signed [ERR_BITS-1:0]    err_reg;
    logic signed [ERRT_BITS-1:0]   errt_reg;
    logic signed [DF_BITS-1:0]     dfreq_reg, dprop_reg;

    // control
    mac_ctl_t mac_ctl;
    logic ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [2*SAMPLE_BITS-1:0] ram_wdata, ram_rdata;
    logic out_load;

    logic signed [ACC_BITS-1:0] low_re, low_im, up_re, up_im;

    // combinational datapath
    logic [PHASE_BITS:0] phase_rnd;
    logic [7:0] sin_idx;
    logic signed [15:0] sn, cs;
    logic signed [ROT_BITS:0] re_sum, im_sum, re_sh, im_sh;
    logic signed [SAMPLE_BITS-1:0] re_sat, im_sat;
    logic signed [LVL_BITS-1:0] lvl_lr, lvl_li, lvl_ur, lvl_ui;
    logic signed [DIFF_BITS-1:0] diff, diff_sh;
    logic signed [ERR_BITS-1:0] err_sat;
    logic signed [ERR_BITS+INV_BITS:0] errt_prod;
    logic signed [ERRT_BITS+GAIN_BITS+1:0] df_prod, dp_prod;
    logic signed [FSUM_BITS-1:0] fsum;
    logic signed [FREQ_BITS-1:0] freq_clamp;
    logic [PHASE_BITS-1:0] phase_new;

    function automatic logic signed [LVL_BITS-1:0] round_acc(
        input logic signed [ACC_BITS-1:0] a);
        logic signed [ACC_BITS-1:0] t;
        t = (a + (ACC_BITS'(1) <<< (SAMPLE_BITS - 3))) >>> (SAMPLE_BITS - 2);
        round_acc = LVL_BITS'(t);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [ROT_BITS:0] v);
        if (v > (ROT_BITS+1)'(SMAX))
            sat_sample = SMAX;
        else if (v < (ROT_BITS+1)'(SMIN))
            sat_sample = SMIN;
        else
            sat_sample = SAMPLE_BITS'(v);
    endfunction

    bef_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (TAP_COUNT)
    ) u_delay_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (raddr_reg),
        .rdata (ram_rdata)
    );

    bef_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .tap    (cnt_reg),
        .rdata  (ram_rdata),
        .low_re (low_re),
        .low_im (low_im),
        .up_re  (up_re),
        .up_im  (up_im)
    );

    // Rotation and loop arithmetic
    always_comb
    begin
        phase_rnd = {1'b0, phase_reg} + PH_HALF;
        sin_idx   = phase_rnd[PHASE_BITS-1 -: 8];
        sn        = sine_at(sin_idx);
        cs        = sine_at(sin_idx + 8'd64);

        re_sum = (ROT_BITS+1)'(p_xc_reg) - (ROT_BITS+1)'(p_ys_reg);
        im_sum = (ROT_BITS+1)'(p_xs_reg) + (ROT_BITS+1)'(p_yc_reg);
        re_sh  = (re_sum + (ROT_BITS+1)'(8192)) >>> 14;
        im_sh  = (im_sum + (ROT_BITS+1)'(8192)) >>> 14;
        re_sat = sat_sample(re_sh);
        im_sat = sat_sample(im_sh);

        lvl_lr = round_acc(low_re);
        lvl_li = round_acc(low_im);
        lvl_ur = round_acc(up_re);
        lvl_ui = round_acc(up_im);

        diff    = DIFF_BITS'(sq_lr_reg) + DIFF_BITS'(sq_li_reg)
                - DIFF_BITS'(sq_ur_reg) - DIFF_BITS'(sq_ui_reg);
        diff_sh = (diff + (DIFF_BITS'(1) <<< 16)) >>> 17;
        if (diff_sh > DIFF_BITS'(ERR_LIMIT))
            err_sat = ERR_BITS'(ERR_LIMIT);
        else if (diff_sh < DIFF_BITS'(-ERR_LIMIT))
            err_sat = ERR_BITS'(-ERR_LIMIT);
        else
            err_sat = ERR_BITS'(diff_sh);

        errt_prod = (ERR_BITS+INV_BITS+1)'(err_reg)
                  * $signed({1'b0, INV_TWO_PI_Q32});
        df_prod = (ERRT_BITS+GAIN_BITS+2)'(errt_reg) * $signed({1'b0, integ_gain_reg});
        dp_prod = (ERRT_BITS+GAIN_BITS+2)'(errt_reg) * $signed({1'b0, prop_gain_reg});

        // integrate first, then advance the phase by the unclamped frequency
        fsum      = FSUM_BITS'(freq_reg) + FSUM_BITS'(dfreq_reg);
        phase_new = phase_reg + fsum[PHASE_BITS-1:0] + dprop_reg[PHASE_BITS-1:0];
        if (fsum > (FSUM_BITS'(1) <<< PHASE_BITS))
            freq_clamp = FREQ_BITS'(1) <<< PHASE_BITS;
        else if (fsum < -(FSUM_BITS'(1) <<< PHASE_BITS))
            freq_clamp = -(FREQ_BITS'(1) <<< PHASE_BITS);
        else
            freq_clamp = FREQ_BITS'(fsum);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_next = cnt_reg + PTR_W'(1);
                if (cnt_reg == LAST_TAP)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_ROT_MUL;
            end
            S_ROT_MUL:
                state_next = S_ROT_SUM;
            S_ROT_SUM:
            begin
                cnt_next   = '0;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                cnt_next = cnt_reg + PTR_W'(1);
                if (cnt_reg == LAST_TAP)
                begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cnt_next = cnt_reg + PTR_W'(1);
                if (cnt_reg == PTR_W'(1))
                begin
                    cnt_next   = '0;
                    state_next = S_SQR;
                end
            end
            S_SQR:
                state_next = S_ERR;
            S_ERR:
                state_next = S_ERRT;
            S_ERRT:
                state_next = S_GAIN;
            S_GAIN:
                state_next = S_DONE;
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        s_tready      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = ptr_reg;
        ram_wdata     = {yq_reg, yi_reg};
        mac_ctl.issue = 1'b0;
        mac_ctl.clear = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = '0;
            end
            S_IDLE:
                s_tready = 1'b1;
            S_ROT_SUM:
            begin
                ram_we        = 1'b1;
                ram_wdata     = {im_sat, re_sat};
                mac_ctl.clear = 1'b1;
            end
            S_MAC:
                mac_ctl.issue = 1'b1;
            S_DONE:
                out_load = !m_tvalid_reg || m_tready;
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cnt_reg        <= '0;
            ptr_reg        <= '0;
            raddr_reg      <= '0;
            prop_gain_reg  <= PROP_GAIN_RESET;
            integ_gain_reg <= INTEG_GAIN_RESET;
            phase_reg      <= '0;
            freq_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                    REG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                    default:        prop_gain_reg  <= prop_gain_reg;
                endcase
            end

            // walk the delay line from the newest entry backwards
            if (state_reg == S_ROT_SUM)
                raddr_reg <= ptr_reg;
            else if (state_reg == S_MAC)
                raddr_reg <= (raddr_reg == '0) ? LAST_TAP : raddr_reg - PTR_W'(1);

            if (out_load)
            begin
                ptr_reg      <= (ptr_reg == LAST_TAP) ? '0 : ptr_reg + PTR_W'(1);
                phase_reg    <= phase_new;
                freq_reg     <= freq_clamp;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            xi_reg <= $signed(s_tdata[SAMPLE_BITS-1:0]);
            xq_reg <= $signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
        end
        if (state_reg == S_ROT_MUL)
        begin
            p_xc_reg <= ROT_BITS'(xi_reg * cs);
            p_ys_reg <= ROT_BITS'(xq_reg * sn);
            p_xs_reg <= ROT_BITS'(xi_reg * sn);
            p_yc_reg <= ROT_BITS'(xq_reg * cs);
        end
        if (state_reg == S_ROT_SUM)
        begin
            yi_reg <= re_sat;
            yq_reg <= im_sat;
        end
        if (state_reg == S_SQR)
        begin
            sq_lr_reg <= SQ_BITS'(lvl_lr * lvl_lr);
            sq_li_reg <= SQ_BITS'(lvl_li * lvl_li);
            sq_ur_reg <= SQ_BITS'(lvl_ur * lvl_ur);
            sq_ui_reg <= SQ_BITS'(lvl_ui * lvl_ui);
        end
        if (state_reg == S_ERR)
            err_reg <= err_sat;
        if (state_reg == S_ERRT)
            errt_reg <= ERRT_BITS'((errt_prod + (ERR_BITS+INV_BITS+1)'(32768)) >>> 16);
        if (state_reg == S_GAIN)
        begin
            dfreq_reg <= DF_BITS'((df_prod + ((ERRT_BITS+GAIN_BITS+2)'(1)
                         <<< (51 - PHASE_BITS))) >>> (52 - PHASE_BITS));
            dprop_reg <= DF_BITS'((dp_prod + ((ERRT_BITS+GAIN_BITS+2)'(1)
                         <<< (51 - PHASE_BITS))) >>> (52 - PHASE_BITS));
        end
        if (out_load)
            m_tdata_reg <= {6'd0, freq_clamp, yq_reg, yi_reg};
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

endmodule

### src/bef_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bef_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 45
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/bef_mac.sv
// Serial complex MAC for the lower and upper band-edge filters.
module bef_mac import bef_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mac_ctl_t                    ctl,
    input  logic [PTR_W-1:0]            tap,
    input  logic [2*SAMPLE_BITS-1:0]    rdata,
    output logic signed [ACC_BITS-1:0]  low_re,
    output logic signed [ACC_BITS-1:0]  low_im,
    output logic signed [ACC_BITS-1:0]  up_re,
    output logic signed [ACC_BITS-1:0]  up_im
);

    logic                        v1_reg;
    logic                        v2_reg;
    logic [PTR_W-1:0]            tap1_reg;
    logic signed [PROD_BITS-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [ACC_BITS-1:0]  lr_reg, li_reg, ur_reg, ui_reg;

    logic signed [COEF_BITS-1:0]   hr, hi;
    logic signed [SAMPLE_BITS-1:0] ar, ai;
    logic signed [ACC_BITS-1:0]    ea, eb, ec, ed;

    always_comb
    begin
        hr = tap_re(tap1_reg);
        hi = tap_im(tap1_reg);
        ar = $signed(rdata[SAMPLE_BITS-1:0]);
        ai = $signed(rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
        ea = ACC_BITS'(pa_reg);
        eb = ACC_BITS'(pb_reg);
        ec = ACC_BITS'(pc_reg);
        ed = ACC_BITS'(pd_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tap1_reg <= tap;
        // products: A = hr*ar, B = hi*ai, C = hr*ai, D = hi*ar
        pa_reg <= PROD_BITS'(hr * ar);
        pb_reg <= PROD_BITS'(hi * ai);
        pc_reg <= PROD_BITS'(hr * ai);
        pd_reg <= PROD_BITS'(hi * ar);
        if (ctl.clear)
        begin
            lr_reg <= '0;
            li_reg <= '0;
            ur_reg <= '0;
            ui_reg <= '0;
        end
        else if (v2_reg)
        begin
            lr_reg <= lr_reg + ea - eb;
            li_reg <= li_reg + ec + ed;
            ur_reg <= ur_reg + ea + eb;
            ui_reg <= ui_reg + ec - ed;
        end
    end

    assign low_re = lr_reg;
    assign low_im = li_reg;
    assign up_re  = ur_reg;
    assign up_im  = ui_reg;

endmodule

### sim/tb.sv
// Self-checking testbench of the band-edge frequency-locked loop carrier recovery block.
module tb;
    import bef_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Field-wise view of one carrier-corrected output transaction.
    typedef struct {
        logic signed [15:0]          rot_i;
        logic signed [15:0]          rot_q;
        logic signed [FREQ_BITS-1:0] freq;
    } corrected_t;

    // Scoreboard: predicts each corrected sample and checks what leaves the block.
    class fll_scoreboard;
        logic signed [15:0] line_i [TAP_COUNT];
        logic signed [15:0] line_q [TAP_COUNT];
        logic [PHASE_BITS-1:0] phase;
        longint freq;
        longint alpha;
        longint beta;
        corrected_t pending [$];
        int mismatches;

        function new();
            foreach (line_i[k])
            begin
                line_i[k] = '0;
                line_q[k] = '0;
            end
            phase = '0;
            freq = 0;
            alpha = longint'(PROP_GAIN_RESET);
            beta = longint'(INTEG_GAIN_RESET);
            mismatches = 0;
        endfunction

        // Round half up by s bits.
        function longint rnd(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint sat(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint quarter_wave(int step);
            int r;
            r = step & 63;
            case ((step >> 6) & 3)
                0:       return longint'(QSINE[r]);
                1:       return longint'(QSINE[64 - r]);
                2:       return -longint'(QSINE[r]);
                default: return -longint'(QSINE[64 - r]);
            endcase
        endfunction

        function void set_gain(logic [CFG_INDEX_BITS-1:0] idx, logic [GAIN_BITS-1:0] val);
            if (idx == REG_PROP_GAIN)
                alpha = longint'(val);
            else if (idx == REG_INTEG_GAIN)
                beta = longint'(val);
        endfunction

        // Note an accepted sample: rotate, filter, advance the loop.
        function void note_sample(logic [31:0] data);
            longint xr, xi, sn, cs, yr, yi, lr, li, ur, ui, hr, hi, ar, ai;
            longint err, errt, next_freq, dprop;
            int step, n, m;
            corrected_t c;
            xr = longint'($signed(data[15:0]));
            xi = longint'($signed(data[31:16]));
            step = int'(((longint'(phase) + (longint'(1) << (PHASE_BITS - 9)))
                    >> (PHASE_BITS - 8)) & 255);
            sn = quarter_wave(step);
            cs = quarter_wave(step + 64);
            yr = sat(rnd(xr * cs - xi * sn, 14), -32768, 32767);
            yi = sat(rnd(xr * sn + xi * cs, 14), -32768, 32767);
            for (int k = TAP_COUNT - 1; k > 0; k--)
            begin
                line_i[k] = line_i[k-1];
                line_q[k] = line_q[k-1];
            end
            line_i[0] = yr[15:0];
            line_q[0] = yi[15:0];
            lr = 0; li = 0; ur = 0; ui = 0;
            for (int k = 0; k < TAP_COUNT; k++)
            begin
                n = k - CENTER_TAP;
                m = n < 0 ? -n : n;
                if (m <= ROM_HALF)
                begin
                    hr = longint'(EDGE_RE[m]);
                    hi = n >= 0 ? longint'(EDGE_IM[m]) : -longint'(EDGE_IM[m]);
                    ar = longint'(line_i[k]);
                    ai = longint'(line_q[k]);
                    lr += hr * ar - hi * ai;
                    li += hr * ai + hi * ar;
                    ur += hr * ar + hi * ai;
                    ui += hr * ai - hi * ar;
                end
            end
            lr = rnd(lr, SAMPLE_BITS - 2);
            li = rnd(li, SAMPLE_BITS - 2);
            ur = rnd(ur, SAMPLE_BITS - 2);
            ui = rnd(ui, SAMPLE_BITS - 2);
            err = sat(rnd(lr * lr + li * li - ur * ur - ui * ui, 17), -ERR_LIMIT, ERR_LIMIT);
            errt = rnd(err * longint'(INV_TWO_PI_Q32), 16);
            next_freq = freq + rnd(errt * beta, 52 - PHASE_BITS);
            dprop = rnd(errt * alpha, 52 - PHASE_BITS);
            phase = PHASE_BITS'(longint'(phase) + next_freq + dprop);
            // Clamp only after the phase has used the raw frequency.
            freq = sat(next_freq, -(longint'(1) << PHASE_BITS), longint'(1) << PHASE_BITS);
            c.rot_i = yr[15:0];
            c.rot_q = yi[15:0];
            c.freq = freq[FREQ_BITS-1:0];
            pending.push_back(c);
        endfunction

        function void check_result(logic [63:0] data);
            corrected_t e;
            corrected_t a;
            a.rot_i = data[15:0];
            a.rot_q = data[31:16];
            a.freq = data[57:32];
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output transaction %h", data);
                return;
            end
            e = pending.pop_front();
            if (a.rot_i !== e.rot_i || a.rot_q !== e.rot_q || a.freq !== e.freq)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp i=%0d q=%0d f=%0d  got i=%0d q=%0d f=%0d",
                             e.rot_i, e.rot_q, e.freq, a.rot_i, a.rot_q, a.freq);
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [31:0]               s_tdata = '0;   // sample_i[15:0], sample_q[31:16]
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [63:0]               m_tdata;        // out_i[15:0], out_q[31:16], freq_word[57:32]
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [GAIN_BITS-1:0]      cfg_data = '0;

    fll_scoreboard board = new();
    bit steady;       // when set, neither side idles
    bit sink_on;      // enables random backpressure on the output

    band_edge_fll_carrier_recovery_top dut (.*);

    always #5 clk = ~clk;

    // Hold-off that a side inserts, with a chance of about 13 in a hundred each time it is asked.
    function automatic bit idle_now();
        return !steady && ($urandom_range(99) < 13);
    endfunction

    // Receive side: random stall, check every accepted output transaction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);
        m_tready <= sink_on && !idle_now();
    end

    // Offer one sample and hold it until the block takes the transaction.
    task automatic push_sample(logic [15:0] si, logic [15:0] sq);
        while (idle_now())
            @(posedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {sq, si};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_sample({sq, si});
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_gain(logic [CFG_INDEX_BITS-1:0] idx, logic [GAIN_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_gain(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Let every expected transaction arrive, then give the pipeline time to settle.
    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (TAP_COUNT + 20)
            @(posedge clk);
    endtask

    // Random burst; a tone at a random rate gives the loop something to lock to.
    task automatic random_burst(int count);
        int tone;
        int ph;
        tone = $urandom_range(255);
        ph = 0;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(3) == 0)
                push_sample(16'($urandom), 16'($urandom));
            else
            begin
                push_sample(16'(board.quarter_wave(ph + 64) >>> $urandom_range(2)),
                            16'(board.quarter_wave(ph) >>> $urandom_range(2)));
                ph = (ph + tone) & 255;
            end
        end
    endtask

    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        sink_on <= 1'b1;
        steady = 1'b0;

        // Directed: extremes of both components plus zero, small and alternating-bit values, with reset gains.
        push_sample(16'h7fff, 16'h7fff);
        push_sample(16'h8000, 16'h8000);
        push_sample(16'h7fff, 16'h8000);
        push_sample(16'h8000, 16'h7fff);
        push_sample(16'h0000, 16'h0000);
        push_sample(16'hffff, 16'h0001);
        push_sample(16'h5555, 16'haaaa);
        push_sample(16'haaaa, 16'h5555);
        drain();

        // Maximum gains drive the error and frequency to their limits.
        write_gain(REG_PROP_GAIN, '1);
        write_gain(REG_INTEG_GAIN, '1);
        write_gain(8'd7, 20'h12345);   // unknown index, ignored
        for (int n = 0; n < 12; n++)
            push_sample(n[0] ? 16'h8000 : 16'h7fff, n[1] ? 16'h7fff : 16'h8000);
        drain();

        // Zero gains freeze the loop.
        write_gain(REG_PROP_GAIN, '0);
        write_gain(REG_INTEG_GAIN, '0);
        random_burst(60);
        drain();

        write_gain(REG_PROP_GAIN, PROP_GAIN_RESET);
        write_gain(REG_INTEG_GAIN, INTEG_GAIN_RESET);
        random_burst(200);
        drain();

        // Steady stretch without idling on either side.
        steady = 1'b1;
        random_burst(120);
        drain();
        steady = 1'b0;

        write_gain(REG_PROP_GAIN, GAIN_BITS'($urandom));
        write_gain(REG_INTEG_GAIN, GAIN_BITS'($urandom_range(65535)));
        write_gain(8'hff, GAIN_BITS'($urandom));
        random_burst(130);
        drain();

        write_gain(REG_PROP_GAIN, '1);
        write_gain(REG_INTEG_GAIN, '1);
        random_burst(120);
        drain();

        if (board.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog well past the slowest correct run.
    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
